// ----- src/pcxd_pkg.sv -----
// Shared types and constants for the PCX body and palette decoder.
package pcxd_pkg;

    localparam int BYTE_W      = 8;
    localparam int RUN_LEN_W   = 6;
    localparam int POS_W       = 25;
    localparam int LIM_W       = POS_W + 1;
    localparam int IDX_W       = 24;
    localparam int CFG_DATA_W  = 25;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_PIXELS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RLE_ENABLE   = 1'd1;

    localparam logic [CFG_DATA_W-1:0] IMAGE_PIXELS_RESET = 25'd64000;
    localparam logic [1:0]            RUN_FLAG           = 2'b11;

    typedef enum logic [1:0] {
        PH_BODY,
        PH_MARKER,
        PH_PALETTE,
        PH_DONE
    } t_phase;

    typedef enum logic {
        ST_ACCEPT,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic accept;
        logic run_step;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic run_more;
        logic run_last;
    } t_sts;

endpackage

// ----- src/pcxd_ctrl.sv -----
// Controller: decides when an input byte is taken and when a run pixel is emitted.
module pcxd_ctrl
    import pcxd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCEPT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.accept   = 1'b0;
        o_cmd.run_step = 1'b0;
        o_stall        = 1'b1;
        unique case (r_state)
            ST_ACCEPT: begin
                o_stall      = !i_sts.out_free;
                o_cmd.accept = i_valid && i_sts.out_free;
                if (o_cmd.accept && i_sts.run_more) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.run_step = i_sts.out_free;
                if (o_cmd.run_step && i_sts.run_last) begin
                    n_state = ST_ACCEPT;
                end
            end
            default: begin
                n_state = ST_ACCEPT;
            end
        endcase
    end

endmodule

// ----- src/pcxd_datapath.sv -----
// Datapath: config registers, decode state, positions and the output register.
module pcxd_datapath
    import pcxd_pkg::*;
#(
    parameter int PIXEL_COUNT_BITS = 24,
    parameter int PALETTE_BYTES    = 768
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [BYTE_W-1:0]      i_in_byte,
    input  logic                   i_stall,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    output logic                   o_valid,
    output logic                   o_out_kind,
    output logic [IDX_W-1:0]       o_out_index,
    output logic [BYTE_W-1:0]      o_out_value,
    output logic                   o_out_last
);

    localparam int PAL_W     = $clog2(PALETTE_BYTES + 1);
    localparam int CAP_SHIFT = (PIXEL_COUNT_BITS >= POS_W) ? POS_W : PIXEL_COUNT_BITS;
    localparam logic [LIM_W-1:0] CAP      = LIM_W'(64'd1 << CAP_SHIFT);
    localparam logic [PAL_W-1:0] PAL_LAST = PAL_W'(PALETTE_BYTES - 1);

    logic [CFG_DATA_W-1:0] r_image_pixels;
    logic                  r_rle_enable;

    t_phase                r_phase,       n_phase;
    logic                  r_run_pending, n_run_pending;
    logic [RUN_LEN_W-1:0]  r_run_len,     n_run_len;
    logic [BYTE_W-1:0]     r_run_value,   n_run_value;
    logic [POS_W-1:0]      r_pos,         n_pos;
    logic [PAL_W-1:0]      r_pal_pos,     n_pal_pos;

    logic                  r_out_valid,   n_out_valid;
    logic                  r_out_kind,    n_out_kind;
    logic [IDX_W-1:0]      r_out_index,   n_out_index;
    logic [BYTE_W-1:0]     r_out_value,   n_out_value;
    logic                  r_out_last,    n_out_last;

    logic [LIM_W-1:0] limit;
    logic [LIM_W-1:0] pos_ext;
    logic [LIM_W-1:0] pos_inc;
    logic             body_full;
    logic             next_full;
    logic             last_px;
    logic             is_run_hdr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_pixels <= IMAGE_PIXELS_RESET;
            r_rle_enable   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_PIXELS: r_image_pixels <= i_cfg_data;
                CFG_RLE_ENABLE:   r_rle_enable   <= i_cfg_data[0];
                default:          r_rle_enable   <= r_rle_enable;
            endcase
        end
    end

    // Pixel limit is the configured count capped at 2^PIXEL_COUNT_BITS (at most 2^POS_W)
    always_comb begin
        limit      = ({1'b0, r_image_pixels} < CAP) ? {1'b0, r_image_pixels} : CAP;
        pos_ext    = {1'b0, r_pos};
        pos_inc    = pos_ext + LIM_W'(1);
        body_full  = pos_ext >= limit;
        next_full  = pos_inc >= limit;
        // run pixel just emitted ends the run: count used up or image end reached
        last_px    = (r_run_len == RUN_LEN_W'(1)) || next_full;
        is_run_hdr = r_rle_enable && (i_in_byte[7:6] == RUN_FLAG);

        o_sts.out_free = !r_out_valid || !i_stall;
        o_sts.run_last = last_px;
        o_sts.run_more = (r_phase == PH_BODY) && !body_full && r_run_pending
                         && (r_run_len != '0) && !last_px;
    end

    always_comb begin
        n_phase       = r_phase;
        n_run_pending = r_run_pending;
        n_run_len     = r_run_len;
        n_run_value   = r_run_value;
        n_pos         = r_pos;
        n_pal_pos     = r_pal_pos;
        n_out_valid   = r_out_valid && i_stall;
        n_out_kind    = r_out_kind;
        n_out_index   = r_out_index;
        n_out_value   = r_out_value;
        n_out_last    = r_out_last;

        if (i_cmd.accept) begin
            unique case (r_phase)
                PH_BODY: begin
                    if (body_full) begin
                        // this byte is taken as the marker
                        n_phase       = PH_PALETTE;
                        n_pal_pos     = '0;
                        n_run_pending = 1'b0;
                        n_run_len     = '0;
                    end else if (r_run_pending) begin
                        n_run_pending = 1'b0;
                        n_run_value   = i_in_byte;
                        if (r_run_len != '0) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = 1'b0;
                            n_out_index = r_pos[IDX_W-1:0];
                            n_out_value = i_in_byte;
                            n_out_last  = last_px;
                            n_pos       = pos_inc[POS_W-1:0];
                            n_run_len   = last_px ? '0 : r_run_len - RUN_LEN_W'(1);
                            if (next_full) begin
                                n_phase = PH_MARKER;
                            end
                        end
                    end else if (is_run_hdr) begin
                        n_run_pending = 1'b1;
                        n_run_len     = i_in_byte[RUN_LEN_W-1:0];
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_kind  = 1'b0;
                        n_out_index = r_pos[IDX_W-1:0];
                        n_out_value = i_in_byte;
                        n_out_last  = 1'b1;
                        n_pos       = pos_inc[POS_W-1:0];
                        if (next_full) begin
                            n_phase = PH_MARKER;
                        end
                    end
                end
                PH_MARKER: begin
                    n_phase   = PH_PALETTE;
                    n_pal_pos = '0;
                end
                PH_PALETTE: begin
                    n_out_valid = 1'b1;
                    n_out_kind  = 1'b1;
                    n_out_index = IDX_W'(r_pal_pos);
                    n_out_value = i_in_byte >> 2;
                    n_out_last  = 1'b1;
                    n_pal_pos   = r_pal_pos + PAL_W'(1);
                    if (r_pal_pos == PAL_LAST) begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end else if (i_cmd.run_step) begin
            n_out_valid = 1'b1;
            n_out_kind  = 1'b0;
            n_out_index = r_pos[IDX_W-1:0];
            n_out_value = r_run_value;
            n_out_last  = last_px;
            n_pos       = pos_inc[POS_W-1:0];
            n_run_len   = last_px ? '0 : r_run_len - RUN_LEN_W'(1);
            if (last_px && next_full) begin
                n_phase = PH_MARKER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_BODY;
            r_run_pending <= 1'b0;
            r_run_len     <= '0;
            r_pos         <= '0;
            r_pal_pos     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_run_pending <= n_run_pending;
            r_run_len     <= n_run_len;
            r_pos         <= n_pos;
            r_pal_pos     <= n_pal_pos;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run_value <= n_run_value;
        r_out_kind  <= n_out_kind;
        r_out_index <= n_out_index;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign o_valid     = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_index = r_out_index;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

endmodule

// ----- src/pcx_rle_body_and_palette_decoder.sv -----
// PCX run-length body and palette decoder, top level.
//
// Input channel: one file byte per transfer on i_in_byte (i_valid / o_stall).
// Output channel: one pixel or palette component per transfer (o_valid / i_stall),
// with o_out_last marking the final result caused by an input byte.
// Config: i_cfg_we writes image_pixels (index 0) or rle_enable (index 1);
// write only while the block is idle.
// Output: a result is registered, in the output register the cycle after its byte transfers.
// Flow: a byte giving zero or one result is taken whenever the output register is
// free; a run data byte gives the run's first pixel, and the input then stalls while
// the single output register, which also emits each run pixel, emits the rest of the run.
// Reset: positions, phase and run state clear, image_pixels returns to 64000
// and rle_enable to 1; no clearing pass, the block is ready right away.
// Receiver stall: the output register holds its result and the input stalls
// until the result transfers.
module pcx_rle_body_and_palette_decoder
    import pcxd_pkg::*;
#(
    parameter int PIXEL_COUNT_BITS = 24,
    parameter int PALETTE_BYTES    = 768
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [BYTE_W-1:0]      i_in_byte,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_out_kind,
    output logic [IDX_W-1:0]       o_out_index,
    output logic [BYTE_W-1:0]      o_out_value,
    output logic                   o_out_last
);

    t_cmd cmd;
    t_sts sts;

    pcxd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    pcxd_datapath #(
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS),
        .PALETTE_BYTES    (PALETTE_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_byte   (i_in_byte),
        .i_stall     (i_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .o_out_kind  (o_out_kind),
        .o_out_index (o_out_index),
        .o_out_value (o_out_value),
        .o_out_last  (o_out_last)
    );

endmodule

// ----- src/pcxd_checker.sv -----
// Port-level checks for the PCX decoder, bound to the top level.
module pcxd_checker
    import pcxd_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_stall,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic [IDX_W-1:0]       o_out_index,
    input logic [BYTE_W-1:0]      o_out_value,
    input logic                   o_out_last
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_index) && $stable(o_out_value)))
        else $error("stalled result changed");

    // no input transfer while a run is still draining
    a_run_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_last) |-> o_stall)
        else $error("input not stalled mid-run");

    // a run continues with the next pixel right after a non-last transfer
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_out_last) |=> o_valid)
        else $error("run pixel missing after transfer");

    // run pixels have consecutive positions
    a_run_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_out_last) |=>
            (o_out_index == $past(o_out_index) + 24'd1))
        else $error("run pixel position not consecutive");

endmodule

bind pcx_rle_body_and_palette_decoder pcxd_checker u_pcxd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_index (o_out_index),
    .o_out_value (o_out_value),
    .o_out_last  (o_out_last)
);

// ----- bench/tb_pcx_rle_body_and_palette_decoder.sv -----
// Self-checking testbench for the PCX run-length body and palette decoder.
`timescale 1ns / 1ps

module tb_pcx_rle_body_and_palette_decoder;
    import pcxd_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PALETTE_LEN  = 768;
    localparam int PALETTE_SENT = 152;
    localparam int PAL_PHASE    = 37;
    localparam logic [LIM_W-1:0] PIXEL_CAP = 26'd16777216;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  index;
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_decoded;

    typedef enum int {
        END_RUN_CUT,
        END_LIMIT_LOWERED,
        END_LIMIT_ZERO
    } t_body_end;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_valid;
    logic                   o_stall;
    logic [BYTE_W-1:0]      i_in_byte;
    logic                   o_valid;
    logic                   i_stall;
    logic                   o_out_kind;
    logic [IDX_W-1:0]       o_out_index;
    logic [BYTE_W-1:0]      o_out_value;
    logic                   o_out_last;

    // decoder state as predicted by the bench
    logic [CFG_DATA_W-1:0] img_pixels;
    logic                  rle_on;
    t_phase                dec_phase;
    logic                  run_armed;
    logic [RUN_LEN_W-1:0]  run_count;
    logic [POS_W-1:0]      pix_pos;
    logic [9:0]            pal_pos;

    t_decoded decoded_q[$];

    int mismatches    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int holds_started = 0;
    int hold_left     = 0;

    pcx_rle_body_and_palette_decoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_byte   (i_in_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_kind  (o_out_kind),
        .o_out_index (o_out_index),
        .o_out_value (o_out_value),
        .o_out_last  (o_out_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // long receiver hold-off, counted here so the sender keeps offering meanwhile
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_started != hold_requests) begin
            hold_left     <= HOLD_CYCLES;
            holds_started <= holds_started + 1;
        end
    end

    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("ERROR @%0d: %s", cycle_count, msg);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_decoded exp;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (decoded_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind=%0d index=%0d value=%0h",
                                          o_out_kind, o_out_index, o_out_value));
            end else begin
                exp = decoded_q.pop_front();
                if (o_out_kind !== exp.kind || o_out_index !== exp.index ||
                    o_out_value !== exp.value || o_out_last !== exp.last) begin
                    report_mismatch($sformatf(
                        "got kind=%0d index=%0d value=%0h last=%0d, want %0d %0d %0h %0d",
                        o_out_kind, o_out_index, o_out_value, o_out_last,
                        exp.kind, exp.index, exp.value, exp.last));
                end
            end
        end
    end

    function automatic void push_decoded(input logic kind, input logic [IDX_W-1:0] index,
                                         input logic [BYTE_W-1:0] value, input logic last);
        t_decoded d;
        d.kind  = kind;
        d.index = index;
        d.value = value;
        d.last  = last;
        decoded_q.push_back(d);
    endfunction

    // predicts the pixels / palette components one file byte produces
    function automatic void decode_file_byte(input logic [BYTE_W-1:0] b);
        logic [LIM_W-1:0] limit;
        logic [LIM_W-1:0] room;
        int unsigned      cnt;
        limit = (img_pixels > PIXEL_CAP) ? PIXEL_CAP : {1'b0, img_pixels};
        if (dec_phase == PH_BODY && {1'b0, pix_pos} >= limit) begin
            // body already full: byte is the marker, pending run dropped
            run_armed = 1'b0;
            run_count = '0;
            dec_phase = PH_PALETTE;
            pal_pos   = '0;
            return;
        end
        case (dec_phase)
            PH_BODY: begin
                if (run_armed) begin
                    room = limit - {1'b0, pix_pos};
                    cnt  = 32'(run_count);
                    if (cnt > room) cnt = 32'(room);
                    for (int i = 0; i < cnt; i++) begin
                        push_decoded(1'b0, pix_pos[IDX_W-1:0], b, i == cnt - 1);
                        pix_pos = pix_pos + 1'b1;
                    end
                    run_armed = 1'b0;
                    run_count = '0;
                end else if (rle_on && b[7:6] == RUN_FLAG) begin
                    run_armed = 1'b1;
                    run_count = b[RUN_LEN_W-1:0];
                end else begin
                    push_decoded(1'b0, pix_pos[IDX_W-1:0], b, 1'b1);
                    pix_pos = pix_pos + 1'b1;
                end
                if ({1'b0, pix_pos} >= limit && !run_armed) dec_phase = PH_MARKER;
            end
            PH_MARKER: begin
                dec_phase = PH_PALETTE;
                pal_pos   = '0;
            end
            PH_PALETTE: begin
                push_decoded(1'b1, {14'd0, pal_pos}, b >> 2, 1'b1);
                pal_pos = pal_pos + 1'b1;
                if (pal_pos >= PALETTE_LEN) dec_phase = PH_DONE;
            end
            default: ;
        endcase
    endfunction

    function automatic void set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        decode_file_byte(b);
    endtask

    // drain all expected results, then give the block time to finish silent bytes
    task automatic settle();
        i_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IMAGE_PIXELS) img_pixels = data;
        else rle_on = data[0];
    endtask

    // well-formed runs and literals, with some arbitrary bytes mixed in
    task automatic send_body_mix(input int count);
        int r;
        int sent;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(99);
            if (!rle_on || r >= 85) begin
                send_byte(8'($urandom_range(255)));
                sent++;
            end else if (r < 45) begin
                send_byte({RUN_FLAG, 6'($urandom_range(63))});
                send_byte(8'($urandom_range(255)));
                sent += 2;
            end else begin
                send_byte(8'($urandom_range(191)));
                sent++;
            end
        end
    endtask

    // runs on the reset configuration: rle on, 64000 pixels
    task automatic test_reset_runs();
        set_idling(8, 8);
        send_byte(8'h00);
        send_byte(8'hBF);
        send_byte(8'h7F);
        send_byte(8'h40);
        send_byte({RUN_FLAG, 6'd3});
        send_byte(8'hAA);
        send_byte({RUN_FLAG, 6'd0});    // zero-length run, data eaten silently
        send_byte(8'h55);
        send_byte({RUN_FLAG, 6'd63});
        send_byte(8'hFF);
        send_byte({RUN_FLAG, 6'd1});
        send_byte(8'h00);
    endtask

    task automatic test_raw_mode();
        write_cfg(CFG_RLE_ENABLE, 25'd0);
        send_byte(8'hFF);
        send_byte(8'hC5);
        send_byte(8'h3C);
    endtask

    // run header in rle mode, data byte after rle is switched off
    task automatic test_mode_change_mid_run();
        write_cfg(CFG_RLE_ENABLE, 25'd1);
        send_byte({RUN_FLAG, 6'd5});
        write_cfg(CFG_RLE_ENABLE, 25'd0);
        send_byte(8'hE1);
        write_cfg(CFG_RLE_ENABLE, 25'd1);
    endtask

    task automatic test_limit_extremes();
        write_cfg(CFG_IMAGE_PIXELS, 25'h1FFFFFF);
        send_byte({RUN_FLAG, 6'd7});
        send_byte(8'h81);
        send_byte(8'h2D);
        write_cfg(CFG_IMAGE_PIXELS, 25'd16777216);
        send_byte(8'h12);
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        if (run_armed) send_byte(8'h11);
        hold_requests++;
        send_byte({RUN_FLAG, 6'd63});
        send_byte(8'h5A);
        for (int i = 0; i < 16; i++) send_byte(8'($urandom_range(191)));
    endtask

    task automatic test_random_body();
        int send_pct[4];
        int recv_pct[4];
        send_pct = '{0, 74, 0, 8};
        recv_pct = '{0, 0, 74, 8};
        for (int ph = 0; ph < 4; ph++) begin
            set_idling(send_pct[ph], recv_pct[ph]);
            write_cfg(CFG_RLE_ENABLE, 25'($urandom_range(3) != 0));
            write_cfg(CFG_IMAGE_PIXELS, 25'($urandom_range(16777216, pix_pos + 50000)));
            send_body_mix(28);
        end
    endtask

    // only one image end per reset, so the way it ends is drawn at random
    task automatic test_image_end();
        t_body_end how;
        int        room;
        how = t_body_end'($urandom_range(2));
        set_idling(8, 8);
        if (run_armed) send_byte(8'h11);
        case (how)
            END_RUN_CUT: begin
                room = $urandom_range(20, 1);
                write_cfg(CFG_RLE_ENABLE, 25'd1);
                write_cfg(CFG_IMAGE_PIXELS, 25'(pix_pos + room));
                send_byte({RUN_FLAG, 6'd63});
                send_byte(8'h9C);
                send_byte({RUN_FLAG, 6'd5});    // marker, not a run header
            end
            END_LIMIT_LOWERED: begin
                write_cfg(CFG_RLE_ENABLE, 25'd1);
                send_byte({RUN_FLAG, 6'd40});
                write_cfg(CFG_IMAGE_PIXELS, 25'($urandom_range(pix_pos - 1, 1)));
                send_byte(8'h6B);
            end
            default: begin
                write_cfg(CFG_IMAGE_PIXELS, 25'd0);
                send_byte(8'h6B);
            end
        endcase
    endtask

    // first part of the palette, under each idling pattern in turn
    task automatic test_palette();
        int send_pct[4];
        int recv_pct[4];
        send_pct = '{0, 74, 0, 8};
        recv_pct = '{0, 0, 74, 8};
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h03);
        send_byte(8'hFC);
        for (int i = 4; i < PALETTE_SENT; i++) begin
            if ((i - 4) % PAL_PHASE == 0) begin
                set_idling(send_pct[(i - 4) / PAL_PHASE], recv_pct[(i - 4) / PAL_PHASE]);
            end
            send_byte(8'($urandom_range(255)));
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_in_byte   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_IMAGE_PIXELS;
        i_cfg_data  <= '0;
        img_pixels = IMAGE_PIXELS_RESET;
        rle_on     = 1'b1;
        dec_phase  = PH_BODY;
        run_armed  = 1'b0;
        run_count  = '0;
        pix_pos    = '0;
        pal_pos    = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_runs();
        test_raw_mode();
        test_mode_change_mid_run();
        test_limit_extremes();
        test_backpressure();
        test_random_body();
        test_image_end();
        test_palette();

        i_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
